// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the keypoint grid search block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define KG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("kgas assertion failed");

// condition must never be seen outside reset
`define KG_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("kgas forbidden condition seen");

`endif

// ===== src/kgas_pkg.sv =====
// ----------------------------------------------------------------------------
// kgas_pkg
// Constants, op codes and the command record shared by the grid search block
// ----------------------------------------------------------------------------
`default_nettype none

package kgas_pkg;

  // grid and store geometry
  localparam int GRID_COLS    = 64;
  localparam int GRID_ROWS    = 48;
  localparam int MAX_FEATURES = 1024;
  localparam int MAX_HITS     = 64;
  localparam int CELLS        = GRID_COLS * GRID_ROWS;

  localparam int CX_W   = $clog2(GRID_COLS);
  localparam int CY_W   = $clog2(GRID_ROWS);
  localparam int CELL_W = $clog2(CELLS);
  localparam int IDX_W  = $clog2(MAX_FEATURES);
  localparam int CNT_W  = IDX_W + 1;
  localparam int HIT_W  = $clog2(MAX_HITS + 1);

  // field widths
  localparam int COORD_W = 16;
  localparam int RAD_W   = 14;
  localparam int OCT_W   = 3;
  localparam int LVL_W   = 4;
  localparam int SCALE_W = 24;
  localparam int FRAC    = 24;
  localparam int KP_W    = 2 * COORD_W + OCT_W;

  // stream widths
  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 3;

  // configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE = 1'b1;
  localparam logic [SCALE_W-1:0]   X_SCALE_RST = 24'd105025;
  localparam logic [SCALE_W-1:0]   Y_SCALE_RST = 24'd105074;

  // command queue
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  // classified item handed from the front to the back
  typedef struct packed {
    op_e                       op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [OCT_W-1:0]          oct;
    logic [RAD_W-1:0]          radius;
    logic [OCT_W-1:0]          min_level;
    logic signed [LVL_W-1:0]   max_level;
    logic [CX_W-1:0]           x_lo;
    logic [CX_W-1:0]           x_hi;
    logic [CY_W-1:0]           y_lo;
    logic [CY_W-1:0]           y_hi;
    logic                      off_grid;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/kgas_front.sv =====
// ----------------------------------------------------------------------------
// kgas_front
// Accepts input items, holds the scale registers and turns coordinates into
// grid cells or clamped cell windows with one shared multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module kgas_front import kgas_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [SCALE_W-1:0]    cfg_data_i,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic [IN_USER_W-1:0]  s_tuser_i,
  output logic                  push_o,
  output cmd_t                  cmd_o,
  input  logic                  full_i
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_POST, F_PUSH} state_e;

  localparam logic [1:0] TGT_X_LO = 2'd0;
  localparam logic [1:0] TGT_X_HI = 2'd1;
  localparam logic [1:0] TGT_Y_LO = 2'd2;
  localparam logic [1:0] TGT_Y_HI = 2'd3;

  localparam logic [42:0] HALF     = 43'(1) << (FRAC - 1);
  localparam logic [42:0] ONE_LESS = (43'(1) << FRAC) - 43'(1);

  state_e             state_q;
  cmd_t               cmd_q;
  logic [1:0]         step_q;
  logic [1:0]         tgt_q;
  logic               pv_q;
  logic signed [41:0] prod_q;
  logic [SCALE_W-1:0] x_scale_q, y_scale_q;

  // scale registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_scale_q <= X_SCALE_RST;
      y_scale_q <= Y_SCALE_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_X_SCALE) x_scale_q <= cfg_data_i;
      if (cfg_idx_i == CFG_Y_SCALE) y_scale_q <= cfg_data_i;
    end
  end

  // operand selection for the current step
  logic               is_query;
  logic [1:0]         tgt, last_step;
  logic signed [16:0] x_ext, y_ext, r_ext, opnd;
  logic [SCALE_W-1:0] scale;
  logic signed [41:0] prod;

  always_comb begin
    is_query  = (cmd_q.op == OP_QUERY);
    last_step = is_query ? 2'd3 : 2'd1;
    tgt       = is_query ? step_q : {step_q[0], 1'b0};
    x_ext     = {cmd_q.x[COORD_W-1], cmd_q.x};
    y_ext     = {cmd_q.y[COORD_W-1], cmd_q.y};
    r_ext     = {3'b000, cmd_q.radius};
    case (tgt)
      TGT_X_LO: opnd = is_query ? (x_ext - r_ext) : x_ext;
      TGT_X_HI: opnd = x_ext + r_ext;
      TGT_Y_LO: opnd = is_query ? (y_ext - r_ext) : y_ext;
      TGT_Y_HI: opnd = y_ext + r_ext;
      default:  opnd = x_ext;
    endcase
    scale = tgt[1] ? y_scale_q : x_scale_q;
    prod  = opnd * $signed({1'b0, scale});
  end

  // rounding, range check and clamping of the registered product
  logic [42:0]        bias;
  logic signed [42:0] psum;
  logic signed [18:0] pcell, lim_m1, pval;
  logic               oob;

  always_comb begin
    if (!is_query) bias = prod_q[41] ? (HALF - 43'(1)) : HALF;
    else if (tgt_q[0]) bias = ONE_LESS;
    else bias = '0;
    psum   = {prod_q[41], prod_q} + $signed(bias);
    pcell  = psum[42:FRAC];
    lim_m1 = tgt_q[1] ? 19'(GRID_ROWS - 1) : 19'(GRID_COLS - 1);
    if (!is_query) begin
      oob  = (pcell < 0) || (pcell > lim_m1);
      pval = pcell;
    end else if (!tgt_q[0]) begin
      oob  = pcell > lim_m1;
      pval = (pcell < 0) ? '0 : pcell;
    end else begin
      oob  = pcell < 0;
      pval = (pcell > lim_m1) ? lim_m1 : pcell;
    end
  end

  // item sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
      pv_q    <= 1'b0;
    end else begin
      pv_q <= (state_q == F_MUL);
      if (pv_q) begin
        cmd_q.off_grid <= cmd_q.off_grid | oob;
        case (tgt_q)
          TGT_X_LO: cmd_q.x_lo <= pval[CX_W-1:0];
          TGT_X_HI: cmd_q.x_hi <= pval[CX_W-1:0];
          TGT_Y_LO: cmd_q.y_lo <= pval[CY_W-1:0];
          default:  cmd_q.y_hi <= pval[CY_W-1:0];
        endcase
      end
      case (state_q)
        F_IDLE: begin
          if (s_tvalid_i) begin
            cmd_q.op        <= op_e'(s_tuser_i);
            cmd_q.x         <= s_tdata_i[15:0];
            cmd_q.y         <= s_tdata_i[31:16];
            cmd_q.oct       <= s_tdata_i[34:32];
            cmd_q.radius    <= s_tdata_i[48:35];
            cmd_q.min_level <= s_tdata_i[51:49];
            cmd_q.max_level <= s_tdata_i[55:52];
            cmd_q.off_grid  <= 1'b0;
            step_q          <= '0;
            if (s_tuser_i == OP_ADD || s_tuser_i == OP_QUERY) state_q <= F_MUL;
            else state_q <= F_PUSH;
          end
        end
        F_MUL: begin
          prod_q <= prod;
          tgt_q  <= tgt;
          if (step_q == last_step) state_q <= F_POST;
          else step_q <= step_q + 2'd1;
        end
        F_POST: state_q <= F_PUSH;
        F_PUSH: if (!full_i) state_q <= F_IDLE;
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign s_tready_o = (state_q == F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign cmd_o      = cmd_q;

endmodule

`default_nettype wire

// ===== src/kgas_fifo.sv =====
// ----------------------------------------------------------------------------
// kgas_fifo
// Short command queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module kgas_fifo import kgas_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_PTR_W:0]   cnt_q;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (FIFO_PTR_W+1)'(push_i) - (FIFO_PTR_W+1)'(pop_i);
    end
  end

  assign full_o  = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

endmodule

`default_nettype wire

// ===== src/kgas_back.sv =====
// ----------------------------------------------------------------------------
// kgas_back
// Executes commands: keypoint store, grid cell lists, area walk and the
// result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kgas_back import kgas_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  output logic [OUT_USER_W-1:0] m_tuser_o,
  output logic                  m_tlast_o
);

  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_ADD_UPD, S_Q_COL, S_Q_CELL, S_Q_HEAD, S_Q_WALK, S_DONE
  } state_e;

  function automatic logic [CELL_W-1:0] cell_of(input logic [CX_W-1:0] cx,
                                                input logic [CY_W-1:0] cy);
    return CELL_W'(cx) * CELL_W'(GRID_ROWS) + CELL_W'(cy);
  endfunction

  // memories
  logic [KP_W-1:0]      kp_mem   [MAX_FEATURES];
  logic [IDX_W-1:0]     nxt_mem  [MAX_FEATURES];
  logic [2*IDX_W-1:0]   cell_mem [CELLS];
  logic [GRID_ROWS-1:0] occ_mem  [GRID_COLS];

  logic [KP_W-1:0]      kp_rd_q;
  logic [IDX_W-1:0]     nxt_rd_q;
  logic [2*IDX_W-1:0]   cell_rd_q;
  logic [GRID_ROWS-1:0] occ_rd_q;

  logic                 kp_we, kp_re, nxt_we, nxt_re, cell_we, cell_re, occ_we, occ_re;
  logic [IDX_W-1:0]     kp_wa, kp_ra, nxt_wa, nxt_ra, nxt_wd;
  logic [KP_W-1:0]      kp_wd;
  logic [CELL_W-1:0]    cell_a;
  logic [2*IDX_W-1:0]   cell_wd;
  logic [CX_W-1:0]      occ_wa, occ_ra;
  logic [GRID_ROWS-1:0] occ_wd;

  always_ff @(posedge clk_i) begin
    if (kp_we) kp_mem[kp_wa] <= kp_wd;
    if (kp_re) kp_rd_q <= kp_mem[kp_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (nxt_re) nxt_rd_q <= nxt_mem[nxt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) cell_mem[cell_a] <= cell_wd;
    if (cell_re) cell_rd_q <= cell_mem[cell_a];
  end

  always_ff @(posedge clk_i) begin
    if (occ_we) occ_mem[occ_wa] <= occ_wd;
    if (occ_re) occ_rd_q <= occ_mem[occ_ra];
  end

  // control and result registers
  state_e           state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CX_W-1:0]  sweep_q, sweep_d, ix_q, ix_d;
  logic [CY_W-1:0]  iy_q, iy_d;
  logic [IDX_W-1:0] j_q, j_d, tail_q, tail_d, pend_idx_q, pend_idx_d;
  logic [HIT_W-1:0] hits_q, hits_d;
  logic             full_q, full_d, pend_v_q, pend_v_d, sweep_emit_q, sweep_emit_d;
  logic             out_v_q, out_v_d, out_hit_q, out_hit_d, out_placed_q, out_placed_d;
  logic             out_ovf_q, out_ovf_d, out_last_q, out_last_d;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;

  // candidate test on the keypoint just read
  logic signed [COORD_W-1:0] kx, ky;
  logic [OCT_W-1:0]          ko;
  logic signed [16:0]        dx, dy;
  logic [16:0]               adx, ady;
  logic                      lvl_check, lvl_ok, match, out_free, stall;

  always_comb begin
    kx        = kp_rd_q[15:0];
    ky        = kp_rd_q[31:16];
    ko        = kp_rd_q[34:32];
    dx        = {kx[15], kx} - {cmd_q.x[15], cmd_q.x};
    dy        = {ky[15], ky} - {cmd_q.y[15], cmd_q.y};
    adx       = dx[16] ? 17'(-dx) : 17'(dx);
    ady       = dy[16] ? 17'(-dy) : 17'(dy);
    lvl_check = (cmd_q.min_level != '0) || !cmd_q.max_level[LVL_W-1];
    lvl_ok    = !lvl_check ||
                ((ko >= cmd_q.min_level) &&
                 (cmd_q.max_level[LVL_W-1] || ({1'b0, ko} <= $unsigned(cmd_q.max_level))));
    match     = lvl_ok && (adx < {3'b000, cmd_q.radius}) && (ady < {3'b000, cmd_q.radius});
  end

  // command sequencer
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    cnt_d        = cnt_q;
    sweep_d      = sweep_q;
    ix_d         = ix_q;
    iy_d         = iy_q;
    j_d          = j_q;
    tail_d       = tail_q;
    pend_idx_d   = pend_idx_q;
    hits_d       = hits_q;
    full_d       = full_q;
    pend_v_d     = pend_v_q;
    sweep_emit_d = sweep_emit_q;
    out_free     = !out_v_q || m_tready_i;
    out_v_d      = out_v_q && !m_tready_i;
    out_idx_d    = out_idx_q;
    out_hit_d    = out_hit_q;
    out_placed_d = out_placed_q;
    out_ovf_d    = out_ovf_q;
    out_last_d   = out_last_q;
    stall        = 1'b0;
    pop_o        = 1'b0;
    kp_we = 1'b0; kp_re = 1'b0; nxt_we = 1'b0; nxt_re = 1'b0;
    cell_we = 1'b0; cell_re = 1'b0; occ_we = 1'b0; occ_re = 1'b0;
    kp_wa   = cnt_q[IDX_W-1:0];
    kp_wd   = {cmd_q.oct, cmd_q.y, cmd_q.x};
    kp_ra   = nxt_rd_q;
    nxt_ra  = nxt_rd_q;
    nxt_wa  = cell_rd_q[IDX_W-1:0];
    nxt_wd  = cnt_q[IDX_W-1:0];
    cell_a  = cell_of(ix_q, iy_q);
    cell_wd = {cnt_q[IDX_W-1:0], cnt_q[IDX_W-1:0]};
    occ_wa  = sweep_q;
    occ_wd  = '0;
    occ_ra  = ix_q;

    case (state_q)
      // clear the occupancy rows one column a cycle
      S_SWEEP: begin
        occ_we = 1'b1;
        if (sweep_q == CX_W'(GRID_COLS - 1)) begin
          state_d = sweep_emit_q ? S_DONE : S_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (!empty_i && out_free) begin
          pop_o    = 1'b1;
          cmd_d    = cmd_i;
          pend_v_d = 1'b0;
          full_d   = 1'b0;
          hits_d   = '0;
          case (cmd_i.op)
            OP_CLEAR: begin
              cnt_d        = '0;
              sweep_d      = '0;
              sweep_emit_d = 1'b1;
              state_d      = S_SWEEP;
            end
            OP_ADD: begin
              if (cnt_q == CNT_W'(MAX_FEATURES)) begin
                out_v_d = 1'b1; out_idx_d = '0; out_hit_d = 1'b0;
                out_placed_d = 1'b0; out_ovf_d = 1'b1; out_last_d = 1'b1;
              end else begin
                kp_we = 1'b1;
                kp_wd = {cmd_i.oct, cmd_i.y, cmd_i.x};
                if (!cmd_i.off_grid) begin
                  occ_re  = 1'b1;
                  occ_ra  = cmd_i.x_lo;
                  cell_re = 1'b1;
                  cell_a  = cell_of(cmd_i.x_lo, cmd_i.y_lo);
                  state_d = S_ADD_UPD;
                end else begin
                  out_v_d = 1'b1; out_idx_d = cnt_q[IDX_W-1:0]; out_hit_d = 1'b0;
                  out_placed_d = 1'b0; out_ovf_d = 1'b0; out_last_d = 1'b1;
                  cnt_d = cnt_q + 1'b1;
                end
              end
            end
            OP_QUERY: begin
              ix_d    = cmd_i.x_lo;
              iy_d    = cmd_i.y_lo;
              state_d = cmd_i.off_grid ? S_DONE : S_Q_COL;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      // link the new keypoint into its cell list
      S_ADD_UPD: begin
        cell_a = cell_of(cmd_q.x_lo, cmd_q.y_lo);
        if (out_free) begin
          cell_we = 1'b1;
          occ_we  = 1'b1;
          occ_wa  = cmd_q.x_lo;
          occ_wd  = occ_rd_q | (GRID_ROWS'(1) << cmd_q.y_lo);
          if (occ_rd_q[cmd_q.y_lo]) begin
            nxt_we  = 1'b1;
            cell_wd = {cell_rd_q[2*IDX_W-1:IDX_W], cnt_q[IDX_W-1:0]};
          end
          out_v_d = 1'b1; out_idx_d = cnt_q[IDX_W-1:0]; out_hit_d = 1'b0;
          out_placed_d = 1'b1; out_ovf_d = 1'b0; out_last_d = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = S_IDLE;
        end
      end
      S_Q_COL: begin
        occ_re  = 1'b1;
        state_d = S_Q_CELL;
      end
      S_Q_CELL: begin
        if (occ_rd_q[iy_q]) begin
          cell_re = 1'b1;
          state_d = S_Q_HEAD;
        end else if (iy_q != cmd_q.y_hi) begin
          iy_d = iy_q + 1'b1;
        end else if (ix_q != cmd_q.x_hi) begin
          ix_d    = ix_q + 1'b1;
          iy_d    = cmd_q.y_lo;
          state_d = S_Q_COL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_Q_HEAD: begin
        j_d     = cell_rd_q[2*IDX_W-1:IDX_W];
        tail_d  = cell_rd_q[IDX_W-1:0];
        kp_re   = 1'b1;
        nxt_re  = 1'b1;
        kp_ra   = cell_rd_q[2*IDX_W-1:IDX_W];
        nxt_ra  = cell_rd_q[2*IDX_W-1:IDX_W];
        state_d = S_Q_WALK;
      end
      // one stored keypoint per cycle unless a hit waits on the output; a
      // hit is held back one step so the final one carries the end marker
      S_Q_WALK: begin
        stall = match && pend_v_q && !out_free;
        if (!stall) begin
          if (match) begin
            if (pend_v_q) begin
              out_v_d = 1'b1; out_idx_d = pend_idx_q; out_hit_d = 1'b1;
              out_placed_d = 1'b0; out_ovf_d = 1'b0; out_last_d = 1'b0;
            end
            pend_v_d   = 1'b1;
            pend_idx_d = j_q;
            hits_d     = hits_q + 1'b1;
          end
          if (match && (hits_q == HIT_W'(MAX_HITS - 1))) begin
            full_d  = 1'b1;
            state_d = S_DONE;
          end else if (j_q != tail_q) begin
            j_d    = nxt_rd_q;
            kp_re  = 1'b1;
            nxt_re = 1'b1;
          end else if (iy_q != cmd_q.y_hi) begin
            iy_d    = iy_q + 1'b1;
            state_d = S_Q_CELL;
          end else if (ix_q != cmd_q.x_hi) begin
            ix_d    = ix_q + 1'b1;
            iy_d    = cmd_q.y_lo;
            state_d = S_Q_COL;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      // final result of a query, clear or unused op
      S_DONE: begin
        if (out_free) begin
          out_v_d      = 1'b1;
          out_idx_d    = pend_v_q ? pend_idx_q : '0;
          out_hit_d    = pend_v_q;
          out_placed_d = 1'b0;
          out_ovf_d    = full_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      sweep_q      <= '0;
      sweep_emit_q <= 1'b0;
      cnt_q        <= '0;
      hits_q       <= '0;
      full_q       <= 1'b0;
      pend_v_q     <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_q      <= sweep_d;
      sweep_emit_q <= sweep_emit_d;
      cnt_q        <= cnt_d;
      hits_q       <= hits_d;
      full_q       <= full_d;
      pend_v_q     <= pend_v_d;
      out_v_q      <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    ix_q         <= ix_d;
    iy_q         <= iy_d;
    j_q          <= j_d;
    tail_q       <= tail_d;
    pend_idx_q   <= pend_idx_d;
    out_idx_q    <= out_idx_d;
    out_hit_q    <= out_hit_d;
    out_placed_q <= out_placed_d;
    out_ovf_q    <= out_ovf_d;
    out_last_q   <= out_last_d;
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = OUT_DATA_W'(out_idx_q);
  assign m_tuser_o  = {out_ovf_q, out_placed_q, out_hit_q};
  assign m_tlast_o  = out_last_q;

  `KG_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(MAX_FEATURES))
  `KG_ASSERT(a_hits_bound, hits_q <= HIT_W'(MAX_HITS))
  `KG_NEVER(a_hit_placed, out_v_q && out_hit_q && out_placed_q)
  `KG_ASSERT(a_full_ends, (state_q == S_Q_WALK) |-> !full_q)

endmodule

`default_nettype wire

// ===== src/keypoint_grid_area_search_core.sv =====
// Keypoint store with a uniform grid index and an area search over it.
// Input stream: tuser carries the op (clear, add, query); tdata carries the
// point, octave, radius and level range. Output stream: tdata carries the
// keypoint index, tuser the hit, placed and overflow flags, tlast ends the
// results of one input. Every input gives at least one result.
// The front takes an item, turns an add's point or a query's window edges
// into cells one after another in its one shared multiplier and pushes
// the command; a clear skips the multiplier. The back takes an on-grid add
// and links it into its cell list. A query is taken, reads the occupancy
// row of each window column, checks each cell, reads each occupied
// cell's head, walks its keypoints one a cycle unless the output stalls.
// A clear, and reset itself, run a sweep over the occupancy memory, one
// grid column a cycle; no item is executed meanwhile, though the front may
// still take one and the queue holds two.
// When the receiver stalls, the output register holds its result and the
// back waits; the queue lets the front keep accepting until it is full.
// Scale registers may be written at any idle time through the cfg port.
// ----------------------------------------------------------------------------
// keypoint_grid_area_search_core
// Top level: front, command queue and back
// ----------------------------------------------------------------------------
`default_nettype none

module keypoint_grid_area_search_core import kgas_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [SCALE_W-1:0]    cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // point_x, point_y, octave, radius, min_level, max_level
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // op
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  // output stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // feature_index, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // hit, placed, overflow
  output logic [OUT_USER_W-1:0] m_axis_tuser_o,
  output logic                  m_axis_tlast_o
);

  cmd_t push_cmd, pop_cmd;
  logic push, full, pop, empty;

  kgas_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  kgas_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_cmd),
    .empty_o (empty)
  );

  kgas_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (pop_cmd),
    .empty_i    (empty),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
